// File: rtl/pre_pkg.sv
// ----------------------------------------------------------------------------
// pre_pkg: shared types and constants of the ribbon extruder
// Field widths, register indexes, line class codes and the structs that
// pass between the sequencer, the multiplier and the search unit.
// ----------------------------------------------------------------------------
package pre_pkg;

  localparam int COORD_W = 32;   // Q24.8 coordinates
  localparam int HW_W    = 12;   // half width, Q4.8
  localparam int IDX_W   = 32;   // vertex index
  localparam int CLS_W   = 2;
  localparam int CFG_W   = 3;    // register index
  localparam int DATA_W  = 32;   // config write data
  localparam int Q_W     = 12;   // normal magnitude bits
  localparam int BIT_W   = 4;    // bit position in the search
  localparam int SQ_W    = 65;   // dx^2 + dy^2
  localparam int R_W     = 88;   // (num * h)^2
  localparam int QS_W    = 77;   // q * S
  localparam int ACC_W   = 90;   // q^2 * S
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 64;
  localparam int HH_W    = 24;

  // register indexes of the config port
  typedef enum logic [CFG_W-1:0] {
    REG_INDEX_HW   = 3'd0,
    REG_FORM_HW    = 3'd1,
    REG_REGULAR_HW = 3'd2,
    REG_OFFSET_X   = 3'd3,
    REG_OFFSET_Y   = 3'd4,
    REG_OFFSET_Z   = 3'd5
  } reg_index_t;

  // line class codes; anything else takes the regular width
  localparam logic [CLS_W-1:0] CLASS_INDEX = 2'd0;
  localparam logic [CLS_W-1:0] CLASS_FORM  = 2'd1;

  // reset half widths
  localparam logic [HW_W-1:0] INDEX_HW_RST   = 12'd480;
  localparam logic [HW_W-1:0] FORM_HW_RST    = 12'd192;
  localparam logic [HW_W-1:0] REGULAR_HW_RST = 12'd269;

  // operand pair of the shared multiplier
  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // search unit status
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } search_res_t;

endpackage

// File: rtl/pre_if.sv
// ----------------------------------------------------------------------------
// pre_if: stream channels of the ribbon extruder
// pre_point_if carries contour points in, pre_vert_if carries vertices out.
// ----------------------------------------------------------------------------
interface pre_point_if import pre_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] contour_height;
  logic        [CLS_W-1:0]   line_class;
  logic                      starts_contour;

  modport source (output valid, point_x, point_y, contour_height, line_class,
                  starts_contour, input ready);
  modport sink   (input valid, point_x, point_y, contour_height, line_class,
                  starts_contour, output ready);
endinterface

interface pre_vert_if import pre_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vert_x;
  logic signed [COORD_W-1:0] vert_y;
  logic signed [COORD_W-1:0] vert_z;
  logic        [IDX_W-1:0]   vertex_index;
  logic                      last_of_quad;

  modport source (output valid, vert_x, vert_y, vert_z, vertex_index,
                  last_of_quad, input ready);
  modport sink   (input valid, vert_x, vert_y, vert_z, vertex_index,
                  last_of_quad, output ready);
endinterface

// File: rtl/pre_mul.sv
// ----------------------------------------------------------------------------
// pre_mul: shared 32x32 unsigned multiplier
// One product per cycle, registered; the sequencer issues and collects.
// ----------------------------------------------------------------------------
module pre_mul import pre_pkg::*; (
  input  logic              clk,
  input  mul_req_t          req,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(req.a) * PROD_W'(req.b);
  end

endmodule

// File: rtl/pre_search.sv
// ----------------------------------------------------------------------------
// pre_search: bit-serial normal magnitude search
// Finds the largest q < 4096 with q^2 * s <= r, MSB first. q^2*s is kept
// incrementally: (q + 2^b)^2 s = q^2 s + (q s << (b+1)) + (s << 2b), so each
// bit needs only shifts and adds. Each bit takes a form step, then a compare step.
// ----------------------------------------------------------------------------
module pre_search import pre_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  s,
  input  logic [R_W-1:0]   r,
  output search_res_t      res
);

  logic             busy;
  logic             phase;
  logic             done;
  logic [BIT_W-1:0] bit_n;
  logic [Q_W-1:0]   q;
  logic [ACC_W-1:0] p_acc;     // q^2 * s
  logic [QS_W-1:0]  qs_acc;    // q * s
  logic [ACC_W-1:0] t_sum;     // trial (q | 2^b)^2 * s
  logic [QS_W-1:0]  qs_try;    // trial (q | 2^b) * s

  // trial terms for the current bit
  logic [ACC_W-1:0] cross_term;
  logic [ACC_W-1:0] sq_term;
  logic [QS_W-1:0]  lin_term;

  always_comb begin
    cross_term = ACC_W'(qs_acc) << ({1'b0, bit_n} + 5'd1);
    sq_term    = ACC_W'(s) << {bit_n, 1'b0};
    lin_term   = QS_W'(s) << bit_n;
  end

  assign res = '{done: done, q: q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      // one-cycle pulse after the last compare
      done <= busy && !start && phase && (bit_n == '0);
      if (start) begin
        busy   <= 1'b1;
        phase  <= 1'b0;
        bit_n  <= BIT_W'(Q_W - 1);
        q      <= '0;
        p_acc  <= '0;
        qs_acc <= '0;
      end else if (busy) begin
        if (!phase) begin
          // form the trial square and product
          t_sum  <= p_acc + cross_term + sq_term;
          qs_try <= qs_acc + lin_term;
          phase  <= 1'b1;
        end else begin
          // keep the bit if the trial still fits
          if (t_sum <= ACC_W'(r)) begin
            p_acc    <= t_sum;
            qs_acc   <= qs_try;
            q[bit_n] <= 1'b1;
          end
          phase <= 1'b0;
          if (bit_n == '0) begin
            busy <= 1'b0;
          end else begin
            bit_n <= bit_n - 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: rtl/polyline_ribbon_extruder_unit.sv
// ----------------------------------------------------------------------------
// polyline_ribbon_extruder_unit: contour polyline to quad ribbon extrusion
//
// Points enter on pt (valid/ready); each point that continues a contour
// closes a segment from the previous point. The segment's normal offset
// n = (-dy, dx) * h / hypot(dx, dy), truncated toward zero, is found by an
// exact bit search, and four vertices p0-n, p0+n, p1+n, p1-n leave on vt,
// offset-subtracted, with a running vertex_index; last_of_quad marks the
// fourth. Registers are written on wr_en / wr_index / wr_data; the user is
// to write them only while idle, which the block itself does not enforce.
// A point that starts a contour gives no quad; a zero-length segment ends
// after the magnitude step. A real segment runs difference and magnitude,
// squares and right-hand sides on the shared multiplier, the two 12-bit
// searches (a form and a compare step per bit) and the vertex hand-out.
// The last vertex sits in the output register while the next point is
// already taken; a stall on vt holds the word, and the sequencer only in
// its emit step. Reset restores the register defaults, clears the previous
// point and the vertex index and empties the output register.
// ----------------------------------------------------------------------------
module polyline_ribbon_extruder_unit import pre_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [CFG_W-1:0]  wr_index,
  input  logic [DATA_W-1:0] wr_data,
  pre_point_if.sink         pt,
  pre_vert_if.source        vt
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_ABS,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
    ST_SX_GO, ST_SX_WAIT, ST_SY_GO, ST_SY_WAIT, ST_EMIT
  } state_t;

  // configuration registers
  logic [HW_W-1:0]    hw_index, hw_form, hw_regular;
  logic [COORD_W-1:0] off_x, off_y, off_z;

  // persistent state
  state_t             state;
  logic [COORD_W-1:0] prev_x, prev_y;
  logic               have_prev;
  logic [IDX_W-1:0]   vidx;

  // per-segment working registers
  logic [COORD_W-1:0] x0, y0, x1, y1, z_in;
  logic [CLS_W-1:0]   cls;
  logic [COORD_W:0]   dx, dy;
  logic [MUL_W-1:0]   adx, ady;
  logic [HW_W-1:0]    h;
  logic [HH_W-1:0]    hh;
  logic [PROD_W-1:0]  ax2, ay2;
  logic [R_W-1:0]     rx, ry;
  logic [SQ_W-1:0]    s_sum;
  logic [Q_W-1:0]     mx, my;
  logic [1:0]         k;

  // output register
  logic               out_valid;
  logic [COORD_W-1:0] o_x, o_y, o_z;
  logic [IDX_W-1:0]   o_idx;
  logic               o_last;

  // shared units
  mul_req_t          mreq;
  logic [PROD_W-1:0] prod;
  logic              srch_start;
  logic [R_W-1:0]    srch_r;
  search_res_t       sres;

  pre_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  pre_search u_search (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .s     (s_sum),
    .r     (srch_r),
    .res   (sres)
  );

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      hw_index   <= INDEX_HW_RST;
      hw_form    <= FORM_HW_RST;
      hw_regular <= REGULAR_HW_RST;
      off_x      <= '0;
      off_y      <= '0;
      off_z      <= '0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_INDEX_HW:   hw_index   <= wr_data[HW_W-1:0];
        REG_FORM_HW:    hw_form    <= wr_data[HW_W-1:0];
        REG_REGULAR_HW: hw_regular <= wr_data[HW_W-1:0];
        REG_OFFSET_X:   off_x      <= wr_data[COORD_W-1:0];
        REG_OFFSET_Y:   off_y      <= wr_data[COORD_W-1:0];
        REG_OFFSET_Z:   off_z      <= wr_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // multiplier operands per sequencer step
  always_comb begin
    mreq = '0;
    case (state)
      ST_M0: mreq = '{a: MUL_W'(h), b: MUL_W'(h)};
      ST_M1: mreq = '{a: adx, b: adx};
      ST_M2: mreq = '{a: ady, b: ady};
      ST_M3: mreq = '{a: ax2[MUL_W-1:0], b: MUL_W'(hh)};
      ST_M4: mreq = '{a: ax2[PROD_W-1:MUL_W], b: MUL_W'(hh)};
      ST_M5: mreq = '{a: ay2[MUL_W-1:0], b: MUL_W'(hh)};
      ST_M6: mreq = '{a: ay2[PROD_W-1:MUL_W], b: MUL_W'(hh)};
      default: mreq = '0;
    endcase
  end

  // search control: x magnitude uses rx, y magnitude uses ry
  assign srch_start = (state == ST_SX_GO) || (state == ST_SY_GO);
  assign srch_r     = (state == ST_SY_GO || state == ST_SY_WAIT) ? ry : rx;

  // magnitudes of the differences
  logic [COORD_W:0] neg_dx, neg_dy;
  logic [HW_W-1:0]  h_sel;

  always_comb begin
    neg_dx = -dx;
    neg_dy = -dy;
    case (cls)
      CLASS_INDEX: h_sel = hw_index;
      CLASS_FORM:  h_sel = hw_form;
      default:     h_sel = hw_regular;
    endcase
  end

  // vertex k: p0-n, p0+n, p1+n, p1-n
  logic [Q_W:0]       nx13, ny13;
  logic [COORD_W-1:0] nx32, ny32, tx, ty, px, py;
  logic               add_n;
  logic               out_free;

  always_comb begin
    nx13  = dy[COORD_W] ? {1'b0, mx} : -{1'b0, mx};
    if (dy == '0) nx13 = '0;
    ny13  = dx[COORD_W] ? -{1'b0, my} : {1'b0, my};
    nx32  = {{(COORD_W-Q_W-1){nx13[Q_W]}}, nx13};
    ny32  = {{(COORD_W-Q_W-1){ny13[Q_W]}}, ny13};
    add_n = k[0] ^ k[1];
    px    = k[1] ? x1 : x0;
    py    = k[1] ? y1 : y0;
    tx    = add_n ? nx32 : -nx32;
    ty    = add_n ? ny32 : -ny32;
  end

  assign out_free = !out_valid || vt.ready;

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
      vidx      <= '0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      // while emitting, the emit step itself refills or holds the word
      if (out_valid && vt.ready && state != ST_EMIT) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (pt.valid) begin
            x0        <= prev_x;
            y0        <= prev_y;
            x1        <= pt.point_x;
            y1        <= pt.point_y;
            z_in      <= pt.contour_height;
            cls       <= pt.line_class;
            prev_x    <= pt.point_x;
            prev_y    <= pt.point_y;
            have_prev <= 1'b1;
            if (have_prev && !pt.starts_contour) state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          dx    <= {x1[COORD_W-1], x1} - {x0[COORD_W-1], x0};
          dy    <= {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
          state <= ST_ABS;
        end
        ST_ABS: begin
          adx   <= dx[COORD_W] ? neg_dx[MUL_W-1:0] : dx[MUL_W-1:0];
          ady   <= dy[COORD_W] ? neg_dy[MUL_W-1:0] : dy[MUL_W-1:0];
          h     <= h_sel;
          // zero-length segment gives no quad
          state <= (dx == '0 && dy == '0) ? ST_IDLE : ST_M0;
        end
        ST_M0: state <= ST_M1;
        ST_M1: begin
          hh    <= prod[HH_W-1:0];
          state <= ST_M2;
        end
        ST_M2: begin
          ax2   <= prod;
          state <= ST_M3;
        end
        ST_M3: begin
          ay2   <= prod;
          state <= ST_M4;
        end
        ST_M4: begin
          ry    <= R_W'(prod);
          state <= ST_M5;
        end
        ST_M5: begin
          ry    <= ry + (R_W'(prod) << MUL_W);
          state <= ST_M6;
        end
        ST_M6: begin
          rx    <= R_W'(prod);
          state <= ST_M7;
        end
        ST_M7: begin
          rx    <= rx + (R_W'(prod) << MUL_W);
          s_sum <= {1'b0, ax2} + {1'b0, ay2};
          state <= ST_SX_GO;
        end
        ST_SX_GO: state <= ST_SX_WAIT;
        ST_SX_WAIT: begin
          if (sres.done) begin
            mx    <= sres.q;
            state <= ST_SY_GO;
          end
        end
        ST_SY_GO: state <= ST_SY_WAIT;
        ST_SY_WAIT: begin
          if (sres.done) begin
            my    <= sres.q;
            k     <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            o_x       <= px + tx - off_x;
            o_y       <= py + ty - off_y;
            o_z       <= z_in - off_z;
            o_idx     <= vidx;
            o_last    <= (k == 2'd3);
            out_valid <= 1'b1;
            vidx      <= vidx + 1'b1;
            k         <= k + 1'b1;
            if (k == 2'd3) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pt.ready        = (state == ST_IDLE);
  assign vt.valid        = out_valid;
  assign vt.vert_x       = o_x;
  assign vt.vert_y       = o_y;
  assign vt.vert_z       = o_z;
  assign vt.vertex_index = o_idx;
  assign vt.last_of_quad = o_last;

endmodule

// File: rtl/pre_checker.sv
// ----------------------------------------------------------------------------
// pre_checker: port-level checks of the ribbon extruder
// Watches the vertex stream and input ready; bound to the top level.
// ----------------------------------------------------------------------------
module pre_checker import pre_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] vert_x,
  input logic [COORD_W-1:0] vert_y,
  input logic [COORD_W-1:0] vert_z,
  input logic [IDX_W-1:0]   vertex_index,
  input logic               last_of_quad
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("vertex word valid right after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vert_x) && $stable(vert_y)
      && $stable(vert_z) && $stable(vertex_index) && $stable(last_of_quad))
    else $error("stalled vertex word changed");

  // quads start on multiples of four
  a_quad_align: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_of_quad == (vertex_index[1:0] == 2'b11)))
    else $error("last_of_quad out of step with vertex_index");

  // inside a quad the next vertex follows at once
  a_quad_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_quad |=>
      out_valid && vertex_index == $past(vertex_index) + 32'd1)
    else $error("gap or skip inside a quad");

  // no new point is taken while a quad is being handed out
  a_busy_in_quad: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_quad |-> !in_ready)
    else $error("point taken in the middle of a quad");

endmodule

bind polyline_ribbon_extruder_unit pre_checker u_pre_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (pt.ready),
  .out_valid    (vt.valid),
  .out_ready    (vt.ready),
  .vert_x       (vt.vert_x),
  .vert_y       (vt.vert_y),
  .vert_z       (vt.vert_z),
  .vertex_index (vt.vertex_index),
  .last_of_quad (vt.last_of_quad)
);

// File: tb/tb_polyline_ribbon_extruder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_ribbon_extruder_unit: self-checking bench for the ribbon extruder
// Sends contour points with random gaps and stalls the vertex side at random.
// Every vertex word is checked, field by field, against a bit-exact quad
// predictor. The run covers several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_polyline_ribbon_extruder_unit;
  import pre_pkg::*;

  localparam int unsigned LIMIT = 500000;
  localparam int SETTLE      = 8;   // wait once the queue is empty, before new register writes
  localparam int DRAIN       = 80;  // wait once the queue is empty, at the end of the run
  localparam int MAX_REPORTS = 10;

  localparam logic [CFG_W-1:0]   REG_SPARE     = 3'd6;
  localparam logic [CLS_W-1:0]   CLASS_REGULAR = 2'd2;
  localparam logic [CLS_W-1:0]   CLASS_SPARE   = 2'd3;
  localparam logic [HW_W-1:0]    HW_MAX        = 12'hfff;
  localparam logic [COORD_W-1:0] C_MAX         = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] C_MIN         = 32'h8000_0000;
  localparam logic [COORD_W-1:0] C_ONES        = 32'hffff_ffff;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [IDX_W-1:0]   idx;
    logic               last;
  } vertex_t;

  // Quad predictor and the queue of vertex words still to come
  class ribbon_scoreboard;
    logic [HW_W-1:0]    hw_index, hw_form, hw_regular;
    logic [COORD_W-1:0] off_x, off_y, off_z;
    logic [COORD_W-1:0] last_x, last_y;
    logic               has_last;
    logic [IDX_W-1:0]   vert_count;
    vertex_t            quad_q[$];
    int                 errors;

    function new();
      hw_index   = INDEX_HW_RST;
      hw_form    = FORM_HW_RST;
      hw_regular = REGULAR_HW_RST;
      off_x      = '0;
      off_y      = '0;
      off_z      = '0;
      last_x     = '0;
      last_y     = '0;
      has_last   = 1'b0;
      vert_count = '0;
      errors     = 0;
    endfunction

    // unknown indexes leave every register as it was
    function void set_reg(logic [CFG_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_INDEX_HW:   hw_index   = data[HW_W-1:0];
        REG_FORM_HW:    hw_form    = data[HW_W-1:0];
        REG_REGULAR_HW: hw_regular = data[HW_W-1:0];
        REG_OFFSET_X:   off_x      = data;
        REG_OFFSET_Y:   off_y      = data;
        REG_OFFSET_Z:   off_z      = data;
        default: ;
      endcase
    endfunction

    // largest q below 2^12 with q^2 * (adx^2 + ady^2) <= (num * h)^2
    function logic [Q_W-1:0] normal_mag(logic [COORD_W-1:0] adx, logic [COORD_W-1:0] ady,
                                        logic [COORD_W-1:0] num, logic [HW_W-1:0] h);
      logic [127:0]   lim, len_sq, trial;
      logic [Q_W-1:0] q, q_try;
      lim    = 128'(num) * 128'(h);
      lim    = lim * lim;
      len_sq = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
      q      = '0;
      for (int b = Q_W - 1; b >= 0; b--) begin
        q_try    = q;
        q_try[b] = 1'b1;
        trial    = 128'(q_try);
        if (trial * trial * len_sq <= lim) q = q_try;
      end
      return q;
    endfunction

    function vertex_t make_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [COORD_W-1:0] z, logic [IDX_W-1:0] idx,
                                  logic last);
      vertex_t v;
      v.x    = x - off_x;
      v.y    = y - off_y;
      v.z    = z;
      v.idx  = idx;
      v.last = last;
      return v;
    endfunction

    // append one expected word at the tail of the queue
    function void add_word(vertex_t v);
      quad_q = {quad_q, v};
    endfunction

    // an accepted point; a segment to the previous point queues one quad
    function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                             logic [COORD_W-1:0] pz, logic [CLS_W-1:0] cls,
                             logic start);
      logic [COORD_W-1:0]      x0, y0, z, nx, ny, adx, ady;
      logic [IDX_W-1:0]        base;
      logic signed [COORD_W:0] dx, dy;
      logic [HW_W-1:0]         h;
      logic [Q_W-1:0]          mx, my;
      logic                    segment;
      x0       = last_x;
      y0       = last_y;
      segment  = has_last && !start;
      last_x   = px;
      last_y   = py;
      has_last = 1'b1;
      dx = $signed({px[COORD_W-1], px}) - $signed({x0[COORD_W-1], x0});
      dy = $signed({py[COORD_W-1], py}) - $signed({y0[COORD_W-1], y0});
      // contour start or zero-length segment: no quad, index unchanged
      if (!segment || (dx == 0 && dy == 0)) return;
      case (cls)
        CLASS_INDEX: h = hw_index;
        CLASS_FORM:  h = hw_form;
        default:     h = hw_regular;
      endcase
      adx = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
      ady = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
      mx  = normal_mag(adx, ady, ady, h);
      my  = normal_mag(adx, ady, adx, h);
      // n points along (-dy, dx)
      nx  = (dy > 0) ? -COORD_W'(mx) : COORD_W'(mx);
      ny  = (dx < 0) ? -COORD_W'(my) : COORD_W'(my);
      z    = pz - off_z;
      base = vert_count;
      add_word(make_vertex(x0 - nx, y0 - ny, z, base,     1'b0));
      add_word(make_vertex(x0 + nx, y0 + ny, z, base + 1, 1'b0));
      add_word(make_vertex(px + nx, py + ny, z, base + 2, 1'b0));
      add_word(make_vertex(px - nx, py - ny, z, base + 3, 1'b1));
      vert_count = base + 4;
    endfunction

    function void check_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [COORD_W-1:0] z, logic [IDX_W-1:0] idx,
                               logic last);
      vertex_t want;
      if (quad_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected vertex word: x=%h y=%h z=%h idx=%0d last=%b",
                   x, y, z, idx, last);
        return;
      end
      want = quad_q.pop_front();
      if (x !== want.x || y !== want.y || z !== want.z || idx !== want.idx ||
          last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("vertex word mismatch at %0t", $realtime);
          $display("  expected x=%h y=%h z=%h idx=%0d last=%b",
                   want.x, want.y, want.z, want.idx, want.last);
          $display("  actual   x=%h y=%h z=%h idx=%0d last=%b", x, y, z, idx, last);
        end
      end
    endfunction

    function int pending();
      return quad_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              wr_en;
  logic [CFG_W-1:0]  wr_index;
  logic [DATA_W-1:0] wr_data;
  int unsigned       cycles = 0;
  bit                src_idle, snk_idle;
  ribbon_scoreboard  quads;

  pre_point_if pts ();
  pre_vert_if  verts ();

  polyline_ribbon_extruder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pt       (pts),
    .vt       (verts)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL polyline_ribbon_extruder_unit");
      $finish;
    end
  end

  // Handshake monitor: vertex words are checked before the point is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (verts.valid && verts.ready)
        quads.check_vertex(verts.vert_x, verts.vert_y, verts.vert_z,
                           verts.vertex_index, verts.last_of_quad);
      if (pts.valid && pts.ready)
        quads.note_point(pts.point_x, pts.point_y, pts.contour_height,
                         pts.line_class, pts.starts_contour);
    end
  end

  // Vertex sink: a random stall, possibly none, before each word when idling is on
  initial begin
    int gap;
    verts.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = snk_idle ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
        verts.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      verts.ready <= 1'b1;
      do @(posedge clk); while (!verts.valid);
      @(negedge clk);
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] x, y, z,
                            input logic [CLS_W-1:0] cls, input logic start);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      pts.valid <= 1'b0;
    end
    @(negedge clk);
    pts.valid          <= 1'b1;
    pts.point_x        <= x;
    pts.point_y        <= y;
    pts.contour_height <= z;
    pts.line_class     <= cls;
    pts.starts_contour <= start;
    do @(posedge clk); while (!pts.ready);
  endtask

  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en <= 1'b0;
    quads.set_reg(idx, data);
  endtask

  // stop sending, wait for every queued vertex, then let the block settle
  task automatic wait_idle(input int extra);
    @(negedge clk);
    pts.valid <= 1'b0;
    while (quads.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  function automatic logic [HW_W-1:0] pick_hw();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return HW_MAX;
      default: return HW_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_offset();
    case ($urandom_range(0, 4))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // sign-extended values of random magnitude
  function automatic logic [COORD_W-1:0] pick_coord();
    return COORD_W'($signed($urandom()) >>> $urandom_range(0, 20));
  endfunction

  function automatic logic [CLS_W-1:0] pick_class();
    if ($urandom_range(0, 7) == 0) return CLASS_SPARE;
    return CLS_W'($urandom_range(0, 2));
  endfunction

  function automatic logic [COORD_W-1:0] pick_step();
    int unsigned span;
    span = 1 << $urandom_range(0, 20);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // One register setting followed by a run of contours
  task automatic random_phase(input int n_items);
    logic [COORD_W-1:0] x, y, z;
    logic [CLS_W-1:0]   cls;
    int                 sent, len, kind;
    wait_idle(SETTLE);
    write_reg(REG_INDEX_HW,   {20'($urandom()), pick_hw()});
    write_reg(REG_FORM_HW,    {20'($urandom()), pick_hw()});
    write_reg(REG_REGULAR_HW, {20'($urandom()), pick_hw()});
    write_reg(REG_OFFSET_X,   pick_offset());
    write_reg(REG_OFFSET_Y,   pick_offset());
    write_reg(REG_OFFSET_Z,   pick_offset());
    write_reg(REG_SPARE,      $urandom());
    src_idle = ($urandom_range(0, 3) != 0);
    snk_idle = ($urandom_range(0, 3) != 0);
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(2, 10);
      x   = pick_coord();
      y   = pick_coord();
      z   = $urandom();
      cls = pick_class();
      // now and then a contour drops its start mark and joins the last one
      send_point(x, y, z, cls, $urandom_range(0, 15) != 0);
      sent++;
      for (int i = 1; i < len && sent < n_items; i++) begin
        kind = $urandom_range(0, 15);
        // kind 0 repeats the point, kind 3 restarts the contour in place
        if (kind == 1) begin
          x = $urandom();
          y = $urandom();
        end else if (kind == 2) begin
          cls = pick_class();
          z   = $urandom();
          x   = x + pick_step();
        end else if (kind == 4) begin
          x = x + pick_step();
        end else if (kind == 5) begin
          y = y + pick_step();
        end else if (kind > 5) begin
          x = x + pick_step();
          y = y + pick_step();
        end
        send_point(x, y, z, cls, kind == 3);
        sent++;
      end
    end
  endtask

  initial begin
    quads              = new();
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = '0;
    wr_data            = '0;
    pts.valid          = 1'b0;
    pts.point_x        = '0;
    pts.point_y        = '0;
    pts.contour_height = '0;
    pts.line_class     = '0;
    pts.starts_contour = 1'b0;
    src_idle           = 1'b1;
    snk_idle           = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset widths and offsets: first point, each class, axis and diagonal
    send_point(32'h0000_0100, 32'h0000_0200, 32'h0000_1000, CLASS_INDEX, 1'b0);
    send_point(32'h0000_0500, 32'h0000_0200, 32'h0000_1000, CLASS_INDEX, 1'b0);
    send_point(32'h0000_0500, -32'sd768,     32'h0000_1000, CLASS_FORM, 1'b0);
    send_point(32'h0000_0500, -32'sd768,     32'h0000_1000, CLASS_REGULAR, 1'b0);
    send_point(32'h0000_0200, 32'h0000_0100, C_MIN,         CLASS_SPARE, 1'b0);
    send_point(C_MAX,         C_MAX,         C_MAX,         CLASS_INDEX, 1'b1);
    send_point(C_MIN,         C_MIN,         C_MAX,         CLASS_FORM, 1'b0);
    send_point(C_MAX,         C_MIN,         C_ONES,        CLASS_REGULAR, 1'b0);

    // Widest ribbons, offsets at the extremes, unit steps
    wait_idle(SETTLE);
    write_reg(REG_INDEX_HW,   C_ONES);
    write_reg(REG_FORM_HW,    C_ONES);
    write_reg(REG_REGULAR_HW, C_ONES);
    write_reg(REG_OFFSET_X,   C_MAX);
    write_reg(REG_OFFSET_Y,   C_MIN);
    write_reg(REG_OFFSET_Z,   C_ONES);
    write_reg(REG_SPARE,      C_ONES);
    send_point('0,     '0,     C_MIN,  CLASS_INDEX, 1'b1);
    send_point(32'd1,  '0,     C_MAX,  CLASS_INDEX, 1'b0);
    send_point(32'd1,  32'd1,  '0,     CLASS_FORM, 1'b0);
    send_point(C_ONES, C_ONES, C_ONES, CLASS_SPARE, 1'b0);
    send_point(C_MIN,  C_MAX,  C_MIN,  CLASS_REGULAR, 1'b0);

    // Zero widths: the ribbon collapses onto the segment
    wait_idle(SETTLE);
    write_reg(REG_INDEX_HW,   '0);
    write_reg(REG_FORM_HW,    '0);
    write_reg(REG_REGULAR_HW, '0);
    write_reg(REG_OFFSET_X,   C_MIN);
    write_reg(REG_OFFSET_Y,   C_MAX);
    write_reg(REG_OFFSET_Z,   '0);
    send_point(32'd5, 32'd5, 32'h0000_0a00, CLASS_INDEX, 1'b1);
    send_point(32'd9, 32'd2, 32'h0000_0a00, CLASS_FORM, 1'b0);
    send_point(32'd9, 32'd2, 32'h0000_0a00, CLASS_REGULAR, 1'b1);
    send_point(32'd4, 32'd7, 32'h0000_0a00, CLASS_SPARE, 1'b0);

    // Random settings and contours, some phases without idling
    for (int p = 0; p < 6; p++) random_phase(72);

    wait_idle(DRAIN);
    if (quads.errors == 0 && quads.pending() == 0)
      $display("PASS polyline_ribbon_extruder_unit");
    else
      $display("FAIL polyline_ribbon_extruder_unit");
    $finish;
  end

endmodule
